// ----- hdl/wfpa_pkg.sv -----
// ----------------------------------------------------------------------------
// Worst-fit partition allocator package
// Sizes, status codes, controller states and the records that travel along
// the chain of partition cells.
// ----------------------------------------------------------------------------
package wfpa_pkg;

  // Array shape
  localparam int NUM_PARTS = 8;
  localparam int SIZE_BITS = 16;
  localparam int IDX_W     = $clog2(NUM_PARTS);

  // Fixed port field widths
  localparam int SLOT_W    = 3;
  localparam int AMT_W     = 16;
  localparam int TOTAL_W   = 19;

  // Adder width for the running total, one bit above the wider operand
  localparam int SUM_W     = ((SIZE_BITS > TOTAL_W) ? SIZE_BITS : TOTAL_W) + 1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_LOADED = 2'd0,
    STAT_ALLOC  = 2'd1,
    STAT_NOFIT  = 2'd2
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_GRANT
  } state_e;

  // Best candidate seen so far, passed from cell to cell
  typedef struct packed {
    logic                 found;
    logic [IDX_W-1:0]     idx;
    logic [SIZE_BITS-1:0] size;
  } cand_t;

  // Write command broadcast to every cell
  typedef struct packed {
    logic                 load;
    logic                 grant;
    logic [IDX_W-1:0]     idx;
    logic [SIZE_BITS-1:0] data;
  } cmd_t;

endpackage

// ----- hdl/worst_fit_partition_allocator_top.sv -----
// ----------------------------------------------------------------------------
// Worst-fit partition allocator
// Fixed partitions held in a chain of cells; an allocation picks the largest
// free partition that fits, lowest index on ties, and adds it to a total.
//
//   Channel  Valid        Stall         Payload
//   in       in_valid_i   in_stall_o    req_type_i, slot_i, amount_i
//   out      out_valid_o  out_stall_i   status_o, chosen_slot_o,
//                                       chosen_size_o, total_allocated_o
//
// A load's result is registered at the accepting edge.
// An allocation walks the request along the chain one cell per cycle, then
// the grant state, once the output is free, updates the winner and the total.
// One transaction is in flight at a time; the input stalls while an allocation runs
// and while a finished result is held by a stalled output.
// Reset leaves every partition busy and the total at zero.
// ----------------------------------------------------------------------------
module worst_fit_partition_allocator_top
  import wfpa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic [SLOT_W-1:0]  slot_i,
  input  logic [AMT_W-1:0]   amount_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [SLOT_W-1:0]  chosen_slot_o,
  output logic [AMT_W-1:0]   chosen_size_o,
  output logic [TOTAL_W-1:0] total_allocated_o
);

  state_e               state_q, state_d;
  logic [IDX_W-1:0]     cnt_q, cnt_d;
  logic [SIZE_BITS-1:0] req_q, req_d;
  logic [TOTAL_W-1:0]   sum_q, sum_d;
  logic                 out_valid_q, out_valid_d;
  status_e              status_q, status_d;
  logic [SLOT_W-1:0]    slot_q, slot_d;
  logic [AMT_W-1:0]     size_q, size_d;

  cmd_t                 cmd;
  cand_t                chain [NUM_PARTS+1];
  cand_t                tail;
  logic                 out_free;
  logic                 in_acc;
  logic                 slot_ok;
  logic [SUM_W-1:0]     sum_add;
  logic [TOTAL_W-1:0]   sum_sat;

  // Handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign slot_ok    = (int'(slot_i) < NUM_PARTS);

  // Chain of partition cells; the head sees an empty candidate.
  assign chain[0] = '0;
  assign tail     = chain[NUM_PARTS];

  for (genvar g = 0; g < NUM_PARTS; g++) begin : g_cell
    wfpa_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(g)),
      .cmd_i      (cmd),
      .req_amt_i  (req_q),
      .cand_i     (chain[g]),
      .cand_o     (chain[g+1])
    );
  end

  // Saturating running total.
  assign sum_add = SUM_W'(sum_q) + SUM_W'(tail.size);
  assign sum_sat = (sum_add > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum_add[TOTAL_W-1:0];

  // Next state, cell commands and result capture.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    req_d       = req_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    slot_d      = slot_q;
    size_d      = size_q;
    cmd         = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (req_type_i == REQ_ALLOC) begin
            req_d   = SIZE_BITS'(amount_i);
            cnt_d   = '0;
            state_d = S_SCAN;
          end else begin
            cmd.load    = slot_ok;
            cmd.idx     = IDX_W'(slot_i);
            cmd.data    = SIZE_BITS'(amount_i);
            out_valid_d = 1'b1;
            status_d    = STAT_LOADED;
            slot_d      = slot_i;
            size_d      = '0;
          end
        end
      end
      S_SCAN: begin
        // The request walks the chain to the tail, one cell per cycle.
        if (cnt_q == IDX_W'(NUM_PARTS - 1)) begin
          state_d = S_GRANT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_GRANT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          if (tail.found) begin
            cmd.grant = 1'b1;
            cmd.idx   = tail.idx;
            sum_d     = sum_sat;
            status_d  = STAT_ALLOC;
            slot_d    = SLOT_W'(tail.idx);
            size_d    = AMT_W'(tail.size);
          end else begin
            status_d  = STAT_NOFIT;
            slot_d    = '0;
            size_d    = '0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    status_q <= status_d;
    slot_q   <= slot_d;
    size_q   <= size_d;
  end

  // The total only moves when a result is written, so it can be shown live.
  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign chosen_slot_o     = slot_q;
  assign chosen_size_o     = size_q;
  assign total_allocated_o = sum_q;

endmodule

// ----- hdl/wfpa_cell.sv -----
// ----------------------------------------------------------------------------
// Partition cell
// Holds one partition's size and busy flag. Each cycle it compares its own
// partition with the candidate from the previous cell and registers the
// better of the two toward the next cell.
// ----------------------------------------------------------------------------
module wfpa_cell
  import wfpa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [IDX_W-1:0]     cell_idx_i,
  input  cmd_t                 cmd_i,
  input  logic [SIZE_BITS-1:0] req_amt_i,
  input  cand_t                cand_i,
  output cand_t                cand_o
);

  logic [SIZE_BITS-1:0] size_q;
  logic                 busy_q;
  cand_t                cand_q;
  cand_t                cand_d;
  logic                 hit;
  logic                 take;

  assign hit = (cmd_i.idx == cell_idx_i);

  // This partition wins if it is free, large enough, and strictly larger than
  // the incoming candidate, so that ties keep the lower index.
  always_comb begin
    take = !busy_q && (size_q >= req_amt_i) &&
           (!cand_i.found || (size_q > cand_i.size));
    if (take) begin
      cand_d.found = 1'b1;
      cand_d.idx   = cell_idx_i;
      cand_d.size  = size_q;
    end else begin
      cand_d = cand_i;
    end
  end

  // Partition size, written by a load.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && hit) begin
      size_q <= cmd_i.data;
    end
  end

  // Busy flag: unavailable after reset, freed by a load, taken by a grant.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else if (cmd_i.load && hit) begin
      busy_q <= 1'b0;
    end else if (cmd_i.grant && hit) begin
      busy_q <= 1'b1;
    end
  end

  // Candidate toward the next cell.
  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
  end

  assign cand_o = cand_q;

endmodule

// ----- test/wfpa_alloc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Worst-fit allocator result checker
// Watches both channels of the allocator. It keeps its own copy of the
// partition table and the running total, works out the result of every
// accepted request and compares each result transaction with the oldest
// expected one, field by field.
// ----------------------------------------------------------------------------
module wfpa_alloc_checker
  import wfpa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               req_type_i,
  input  logic [SLOT_W-1:0]  slot_i,
  input  logic [AMT_W-1:0]   amount_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [1:0]         status_i,
  input  logic [SLOT_W-1:0]  chosen_slot_i,
  input  logic [AMT_W-1:0]   chosen_size_i,
  input  logic [TOTAL_W-1:0] total_allocated_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 results_o,
  output int                 loads_o,
  output int                 grants_o,
  output int                 misses_o
);

  typedef struct packed {
    status_e              status;
    logic [SLOT_W-1:0]    slot;
    logic [AMT_W-1:0]     size;
    logic [TOTAL_W-1:0]   total;
  } alloc_result_t;

  // Shadow partition table and running total.
  logic [SIZE_BITS-1:0] part_len [NUM_PARTS];
  logic                 part_free [NUM_PARTS];
  longint unsigned      granted_total;

  alloc_result_t        awaited_results [$];

  // Apply one request to the shadow table and return the result it causes.
  function automatic alloc_result_t grant_partition(input logic kind,
                                                    input logic [SLOT_W-1:0] slot,
                                                    input logic [AMT_W-1:0] amount);
    alloc_result_t        res;
    logic [SIZE_BITS-1:0] want;
    logic                 found;
    int                   best;
    res   = '0;
    want  = SIZE_BITS'(amount);
    found = 1'b0;
    best  = 0;
    if (kind == REQ_LOAD) begin
      if (int'(slot) < NUM_PARTS) begin
        part_len[slot]  = want;
        part_free[slot] = 1'b1;
      end
      res.status = STAT_LOADED;
      res.slot   = slot;
    end else begin
      // Largest free partition that fits; a strict compare keeps the lowest index on ties.
      for (int j = 0; j < NUM_PARTS; j++) begin
        if (part_free[j] && part_len[j] >= want && (!found || part_len[j] > part_len[best])) begin
          found = 1'b1;
          best  = j;
        end
      end
      if (found) begin
        part_free[best] = 1'b0;
        granted_total   = granted_total + part_len[best];
        if (granted_total > longint'(TOTAL_MAX)) begin
          granted_total = longint'(TOTAL_MAX);
        end
        res.status = STAT_ALLOC;
        res.slot   = SLOT_W'(best);
        res.size   = AMT_W'(part_len[best]);
      end else begin
        res.status = STAT_NOFIT;
      end
    end
    res.total = TOTAL_W'(granted_total);
    return res;
  endfunction

  // Check the result transaction first, then record the new request.
  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t seen;
    alloc_result_t want;
    if (!rst_ni) begin
      for (int j = 0; j < NUM_PARTS; j++) begin
        part_len[j]  = '0;
        part_free[j] = 1'b0;
      end
      granted_total = 0;
      awaited_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
      results_o    = 0;
      loads_o      = 0;
      grants_o     = 0;
      misses_o     = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        seen.status = status_e'(status_i);
        seen.slot   = chosen_slot_i;
        seen.size   = chosen_size_i;
        seen.total  = total_allocated_i;
        results_o++;
        if (awaited_results.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) begin
            $display("tb: result %0d arrived with nothing expected: status %0d slot %0d",
                     results_o, seen.status, seen.slot, " size %0d total %0d",
                     seen.size, seen.total);
          end
        end else begin
          want = awaited_results.pop_front();
          if (seen.status !== want.status || seen.slot !== want.slot ||
              seen.size !== want.size || seen.total !== want.total) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("tb: result %0d mismatch: expected status %0d slot %0d size %0d",
                       results_o, want.status, want.slot, want.size,
                       " total %0d; got status %0d slot %0d size %0d total %0d",
                       want.total, seen.status, seen.slot, seen.size, seen.total);
            end
          end
          case (want.status)
            STAT_LOADED: loads_o++;
            STAT_ALLOC:  grants_o++;
            default:     misses_o++;
          endcase
        end
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_results.push_back(grant_partition(req_type_i, slot_i, amount_i));
      end
      pending_o = awaited_results.size();
    end
  end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Worst-fit partition allocator testbench
// Drives load and allocate requests into the allocator: a directed opening
// that hits full and empty tables, ties, zero sizes, reloads and a saturated
// total, then random load/allocate rounds mixed with noise. Both channels
// idle at random; the checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module tb;
  import wfpa_pkg::*;

  localparam int REQUEST_TARGET = 1650;
  localparam int STUCK_LIMIT    = 2000;
  localparam int HOLD_CYCLES    = 80;
  localparam int SETTLE_CYCLES  = 20;

  logic               clk_i;
  logic               rst_ni            = 1'b0;
  logic               in_valid_i        = 1'b0;
  logic               in_stall_o;
  logic               req_type_i        = REQ_LOAD;
  logic [SLOT_W-1:0]  slot_i            = '0;
  logic [AMT_W-1:0]   amount_i          = '0;
  logic               out_valid_o;
  logic               out_stall_i       = 1'b0;
  logic [1:0]         status_o;
  logic [SLOT_W-1:0]  chosen_slot_o;
  logic [AMT_W-1:0]   chosen_size_o;
  logic [TOTAL_W-1:0] total_allocated_o;

  int fail_count;
  int pending;
  int results;
  int loads;
  int grants;
  int misses;
  int requests_sent = 0;

  worst_fit_partition_allocator_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .req_type_i        (req_type_i),
    .slot_i            (slot_i),
    .amount_i          (amount_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .chosen_slot_o     (chosen_slot_o),
    .chosen_size_o     (chosen_size_o),
    .total_allocated_o (total_allocated_o)
  );

  wfpa_alloc_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .req_type_i        (req_type_i),
    .slot_i            (slot_i),
    .amount_i          (amount_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_i          (status_o),
    .chosen_slot_i     (chosen_slot_o),
    .chosen_size_i     (chosen_size_o),
    .total_allocated_i (total_allocated_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .results_o         (results),
    .loads_o           (loads),
    .grants_o          (grants),
    .misses_o          (misses)
  );

  // 100 MHz clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offer one request, with optional idle cycles first, and return at the
  // falling edge after the transaction has been accepted.
  task automatic send_request(input logic kind, input logic [SLOT_W-1:0] slot,
                              input logic [AMT_W-1:0] amount);
    bit steady;
    steady = (requests_sent >= 300 && requests_sent < 650);
    while (!steady && $urandom_range(0, 99) < 12) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    slot_i     <= slot;
    amount_i   <= amount;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    requests_sent++;
    @(negedge clk_i);
  endtask

  // Partition sizes: mostly small, with the extremes and the full range mixed in.
  function automatic logic [AMT_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return AMT_W'($urandom_range(0, 65535));
      default: return AMT_W'($urandom_range(0, 1023));
    endcase
  endfunction

  // Request stream.
  initial begin : stimulus
    logic [AMT_W-1:0]  loaded_len [NUM_PARTS];
    logic [AMT_W-1:0]  base_len;
    logic [AMT_W-1:0]  ask;
    logic [SLOT_W-1:0] s;
    int                load_count;
    int                alloc_count;
    bit                drained;
    for (int p = 0; p < NUM_PARTS; p++) loaded_len[p] = '0;
    drained = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Nothing is loaded yet, so even a zero-size request misses.
    send_request(REQ_ALLOC, 3'd0, 16'd0);
    // Fill every partition with the largest size and drain them again: equal
    // sizes go out lowest index first while the total climbs.
    for (int p = 0; p < NUM_PARTS; p++) send_request(REQ_LOAD, SLOT_W'(p), '1);
    for (int p = 0; p < NUM_PARTS; p++) send_request(REQ_ALLOC, SLOT_W'(p ^ 5), '1);
    // Every partition is busy now.
    send_request(REQ_ALLOC, 3'd7, 16'd1);
    // Reloading a busy partition frees it; granting it again saturates the total.
    send_request(REQ_LOAD, 3'd3, 16'hFFFF);
    send_request(REQ_ALLOC, 3'd0, 16'd0);
    // A zero-size partition still satisfies a zero-size request.
    send_request(REQ_LOAD, 3'd5, 16'd0);
    send_request(REQ_ALLOC, 3'd2, 16'd0);
    // Worst fit takes the larger of two free partitions; one unit more misses.
    send_request(REQ_LOAD, 3'd1, 16'd100);
    send_request(REQ_LOAD, 3'd6, 16'd200);
    send_request(REQ_ALLOC, 3'd0, 16'd201);
    send_request(REQ_ALLOC, 3'd4, 16'd50);

    // Random part: mostly load rounds followed by allocations sized around the
    // loaded partitions, with some unrelated requests as noise.
    while (requests_sent < REQUEST_TARGET) begin
      if (!drained && requests_sent >= 1200) begin
        // Let the block run dry before going on.
        in_valid_i <= 1'b0;
        @(negedge clk_i);
        while (pending != 0) @(negedge clk_i);
        drained = 1'b1;
      end
      if ($urandom_range(0, 99) < 80) begin
        load_count = $urandom_range(1, NUM_PARTS);
        base_len   = pick_size();
        for (int k = 0; k < load_count; k++) begin
          s = SLOT_W'($urandom_range(0, NUM_PARTS - 1));
          loaded_len[s] = ($urandom_range(0, 2) == 0) ? base_len : pick_size();
          send_request(REQ_LOAD, SLOT_W'($urandom_range(0, 7)) & '0 | s, loaded_len[s]);
        end
        alloc_count = $urandom_range(1, load_count + 1);
        for (int k = 0; k < alloc_count; k++) begin
          s = SLOT_W'($urandom_range(0, NUM_PARTS - 1));
          case ($urandom_range(0, 4))
            0:       ask = loaded_len[s];
            1:       ask = (loaded_len[s] > 3) ? loaded_len[s] - AMT_W'($urandom_range(1, 3))
                                               : '0;
            2:       ask = loaded_len[s] + 1'b1;
            3:       ask = AMT_W'($urandom_range(0, 255));
            default: ask = pick_size();
          endcase
          send_request(REQ_ALLOC, SLOT_W'($urandom_range(0, 7)), ask);
        end
      end else begin
        send_request(1'($urandom_range(0, 1)), SLOT_W'($urandom_range(0, 7)),
                     AMT_W'($urandom_range(0, 65535)));
      end
    end
    in_valid_i <= 1'b0;

    // Wait for the last results, then a little longer for strays.
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    $display("tb: %0d requests sent; %0d load, %0d grant and %0d miss results checked",
             requests_sent, loads, grants, misses);
    $display("tb: included one %0d-cycle output hold-off and one full drain",
             HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off, and a stretch with none.
  initial begin : result_sink
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && results >= 500) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (results >= 900 && results < 1200) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < 12);
      end
    end
  end

  // Ends the run when no transaction moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STUCK_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb: no transaction for %0d cycles, %0d results outstanding",
             STUCK_LIMIT, pending);
    $display("tb: failure");
    $finish;
  end

endmodule
